>>> rtl/variable_edge_histogram_unit_macros.svh
// Assertion macros for the variable edge histogram unit.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef VARIABLE_EDGE_HISTOGRAM_UNIT_MACROS_SVH
`define VARIABLE_EDGE_HISTOGRAM_UNIT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define VEHU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define VEHU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/vehu_pkg.sv
// ----------------------------------------------------------------------------
// vehu_pkg
// Types, codes and floating point compare helpers of the edge histogram.
// ----------------------------------------------------------------------------
package vehu_pkg;

  localparam int unsigned MaxBinsDefault = 256;
  localparam int unsigned CountBitsDefault = 32;
  // Largest supported bin count; search words are sized for it.
  localparam int unsigned MaxBinsHigh = 4096;
  localparam int unsigned SrchW = $clog2(MaxBinsHigh + 2);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } vehu_op_e;

  typedef enum logic [1:0] {
    CFG_SKIP_ZEROS = 2'd0,
    CFG_SKIP_NANS  = 2'd1,
    CFG_SKIP_INFS  = 2'd2,
    CFG_BINS       = 2'd3
  } vehu_cfg_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [8:0]  slot;
    logic [63:0] sample_bits;
    logic        in_mask;
  } vehu_in_t;

  typedef struct packed {
    logic [7:0]  read_bin;
    logic [31:0] bin_total;
  } vehu_out_t;

  // One step of the upper-bound search as it moves down the cell row.
  typedef struct packed {
    logic            valid;
    logic [SrchW-1:0] first;
    logic [SrchW-1:0] len;
  } vehu_srch_t;

  function automatic logic fp_is_nan(input logic [63:0] a);
    return (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
  endfunction

  // IEEE less-than: false on NaN, and the two zeros compare equal.
  function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
    logic res;
    res = 1'b0;
    if (fp_is_nan(a) || fp_is_nan(b)) begin
      res = 1'b0;
    end else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
      res = 1'b0;
    end else if (a[63] != b[63]) begin
      res = a[63];
    end else if (!a[63]) begin
      res = a[62:0] < b[62:0];
    end else begin
      res = a[62:0] > b[62:0];
    end
    return res;
  endfunction

  function automatic logic fp_eq(input logic [63:0] a, input logic [63:0] b);
    logic res;
    res = 1'b0;
    if (fp_is_nan(a) || fp_is_nan(b)) begin
      res = 1'b0;
    end else begin
      res = (a == b) || ((a[62:0] == 63'd0) && (b[62:0] == 63'd0));
    end
    return res;
  endfunction

endpackage

>>> rtl/vehu_ram.sv
// ----------------------------------------------------------------------------
// vehu_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module vehu_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 257,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/vehu_cell.sv
// ----------------------------------------------------------------------------
// vehu_cell
// One step of the upper-bound edge search: probe, read, compare, hand on.
// ----------------------------------------------------------------------------
module vehu_cell
  import vehu_pkg::*;
#(
  parameter int unsigned AddrW = 9,
  parameter int unsigned MaxProbe = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [63:0]      sample_i,
  input  vehu_srch_t       step_i,
  input  logic [63:0]      rdata_i,
  output vehu_srch_t       step_o,
  output logic [AddrW-1:0] rd_addr_o
);

  vehu_srch_t       a_q;
  vehu_srch_t       b_q;
  logic [SrchW-1:0] probe_q;
  logic [SrchW-1:0] half_q;
  logic [SrchW-1:0] half;
  logic [SrchW:0]   sum;
  logic [SrchW-1:0] probe;

  // The first stage issues the probe address; the edge is back in the next cycle.
  always_comb begin
    half = a_q.len >> 1;
    sum = {1'b0, a_q.first} + {1'b0, half};
    if (sum > (SrchW + 1)'(MaxProbe)) begin
      probe = SrchW'(MaxProbe);
    end else begin
      probe = sum[SrchW-1:0];
    end
    rd_addr_o = (a_q.valid && (a_q.len != '0)) ? AddrW'(probe) : '0;
  end

  always_comb begin
    step_o = b_q;
    if (b_q.valid && (b_q.len != '0)) begin
      if (!fp_lt(sample_i, rdata_i)) begin
        step_o.first = probe_q + SrchW'(1);
        step_o.len = b_q.len - half_q - SrchW'(1);
      end else begin
        step_o.len = half_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
    end else begin
      a_q <= step_i;
      b_q <= a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q <= probe;
    half_q <= half;
  end

endmodule

>>> rtl/variable_edge_histogram_unit.sv
// ----------------------------------------------------------------------------
// variable_edge_histogram_unit
// Histogram of double samples over a loaded, sorted table of bin edges.
// ----------------------------------------------------------------------------
// Load and clear beats end as they are taken. A searched sample reads both
// outer edges, then STEPS = clog2(MAX_BINS+2) search cells each wait on one
// edge read. Samples dropped on mask, NaN or a skip return to idle, those
// outside the outer edges after the range check, and those on the last edge
// skip the search. One beat is in work at a time. Reset clears configuration,
// control state and every count; the edge table is undefined until loaded.
module variable_edge_histogram_unit
  import vehu_pkg::*;
#(
  parameter int unsigned MAX_BINS = MaxBinsDefault,
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  vehu_in_t   in_beat_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output vehu_out_t  out_beat_o
);

  localparam int unsigned EdgeW = $clog2(MAX_BINS + 1);
  localparam int unsigned BinW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned Steps = $clog2(MAX_BINS + 2);

  typedef enum logic [3:0] {
    S_IDLE, S_LO, S_HI, S_CHK, S_SRCH, S_CRD, S_CWR, S_RRD, S_ROUT
  } state_e;

  state_e state_q;

  // Configuration registers. The NaN skip register is write-only for software:
  // NaN samples are always dropped, so nothing is stored for it.
  logic       skip_zeros_q;
  logic       skip_infs_q;
  logic [8:0] bins_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_zeros_q <= 1'b0;
      skip_infs_q <= 1'b0;
      bins_q <= 9'd1;
    end else if (cfg_we_i) begin
      unique case (vehu_cfg_e'(cfg_index_i))
        CFG_SKIP_ZEROS: skip_zeros_q <= cfg_data_i[0];
        CFG_SKIP_NANS:  ;
        CFG_SKIP_INFS:  skip_infs_q <= cfg_data_i[0];
        CFG_BINS:       bins_q <= cfg_data_i;
      endcase
    end
  end

  // Active bin count, clamped to 1..MAX_BINS.
  logic [EdgeW-1:0] n_bins;
  always_comb begin
    if (bins_q == 9'd0) begin
      n_bins = EdgeW'(1);
    end else if (32'(bins_q) > MAX_BINS) begin
      n_bins = EdgeW'(MAX_BINS);
    end else begin
      n_bins = EdgeW'(bins_q);
    end
  end

  logic in_acc;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;

  // A sample is dropped up front on its mask, on NaN, and on the zero and
  // infinity skips; the range test needs both outer edges and comes later.
  logic drop;
  always_comb begin
    drop = !in_beat_i.in_mask || fp_is_nan(in_beat_i.sample_bits)
        || (skip_zeros_q && (in_beat_i.sample_bits[62:0] == 63'd0))
        || (skip_infs_q && (in_beat_i.sample_bits[62:52] == 11'h7FF));
  end

  // Edge table.
  logic             edge_we;
  logic [EdgeW-1:0] edge_raddr;
  logic [63:0]      edge_rdata;

  assign edge_we = in_acc && (vehu_op_e'(in_beat_i.opcode) == OP_LOAD)
      && (32'(in_beat_i.slot) <= MAX_BINS);

  vehu_ram #(
    .Width(64),
    .Depth(MAX_BINS + 1)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (edge_we),
    .waddr_i(EdgeW'(in_beat_i.slot)),
    .wdata_i(in_beat_i.sample_bits),
    .raddr_i(edge_raddr),
    .rdata_o(edge_rdata)
  );

  // Search row. The launch enters cell 0; each cell registers first/len in its
  // probe and compare stages and passes them on. Only one cell reads the edge
  // table at a time, so the cell addresses are simply ORed onto the read port.
  logic [63:0]      v_q;
  logic [63:0]      lo_q;
  vehu_srch_t       launch;
  vehu_srch_t       step [Steps+1];
  logic [EdgeW-1:0] cell_addr [Steps];
  logic [EdgeW-1:0] srch_addr;

  assign step[0] = launch;

  for (genvar k = 0; k < Steps; k++) begin : g_cell
    vehu_cell #(
      .AddrW   (EdgeW),
      .MaxProbe(MAX_BINS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .sample_i (v_q),
      .step_i   (step[k]),
      .rdata_i  (edge_rdata),
      .step_o   (step[k+1]),
      .rd_addr_o(cell_addr[k])
    );
  end

  always_comb begin
    srch_addr = '0;
    for (int k = 0; k < Steps; k++) begin
      srch_addr = srch_addr | cell_addr[k];
    end
  end

  always_comb begin
    unique case (state_q)
      S_HI:    edge_raddr = n_bins;
      S_SRCH:  edge_raddr = srch_addr;
      default: edge_raddr = '0;
    endcase
  end

  // Bin chosen by the search: the last edge not above the sample, clamped
  // to the last active bin for unsorted tables.
  logic [SrchW-1:0] found;
  logic [BinW-1:0]  found_bin;
  always_comb begin
    found = step[Steps].first;
    if (found == '0) begin
      found = '0;
    end else begin
      found = found - SrchW'(1);
    end
    if (found > SrchW'(n_bins - EdgeW'(1))) begin
      found = SrchW'(n_bins - EdgeW'(1));
    end
    found_bin = BinW'(found);
  end

  // Counts. Per-bin valid flops stand for the cleared state, so both reset
  // and the clear beat take effect at once.
  logic [BinW-1:0]       bin_q;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic [COUNT_BITS-1:0] cnt_cur;
  logic [COUNT_BITS-1:0] cnt_next;
  logic [MAX_BINS-1:0]   cnt_valid_q;
  logic                  cnt_we;

  assign cnt_cur = cnt_valid_q[bin_q] ? cnt_rdata : '0;
  assign cnt_next = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
  assign cnt_we = (state_q == S_CWR);

  vehu_ram #(
    .Width(COUNT_BITS),
    .Depth(MAX_BINS)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(bin_q),
    .wdata_i(cnt_next),
    .raddr_i(bin_q),
    .rdata_o(cnt_rdata)
  );

  logic [7:0] rd_slot_q;
  logic       rd_beyond_q;

  // In the check state edge_rdata holds the last active edge. A search is
  // launched only for a sample that lies inside the edges and is not equal
  // to the last one, so no stray search can share the row with a later one.
  logic chk_out;
  logic chk_top;
  assign chk_out = fp_lt(v_q, lo_q) || fp_lt(edge_rdata, v_q);
  assign chk_top = fp_eq(v_q, edge_rdata);

  always_comb begin
    launch.valid = (state_q == S_CHK) && !chk_out && !chk_top;
    launch.first = '0;
    launch.len = SrchW'(n_bins) + SrchW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_o <= 1'b0;
      out_beat_o <= '0;
      cnt_valid_q <= '0;
    end else begin
      // A taken result beat frees the output register unless a new one is
      // loaded in the same cycle.
      if (out_valid_o && !out_stall_i && (state_q != S_ROUT)) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (vehu_op_e'(in_beat_i.opcode))
              OP_LOAD:   ;
              OP_SAMPLE: if (!drop) state_q <= S_LO;
              OP_READ:   state_q <= S_RRD;
              OP_CLEAR:  cnt_valid_q <= '0;
            endcase
          end
        end
        S_LO: state_q <= S_HI;
        S_HI: state_q <= S_CHK;
        S_CHK: begin
          if (chk_out) begin
            state_q <= S_IDLE;
          end else if (chk_top) begin
            state_q <= S_CRD;
          end else begin
            state_q <= S_SRCH;
          end
        end
        S_SRCH: if (step[Steps].valid) state_q <= S_CRD;
        S_CRD:  state_q <= S_CWR;
        S_CWR: begin
          cnt_valid_q[bin_q] <= 1'b1;
          state_q <= S_IDLE;
        end
        S_RRD: state_q <= S_ROUT;
        S_ROUT: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o <= 1'b1;
            out_beat_o.read_bin <= rd_slot_q;
            out_beat_o.bin_total <= rd_beyond_q ? 32'd0 : 32'(cnt_cur);
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v_q <= in_beat_i.sample_bits;
      rd_slot_q <= in_beat_i.slot[7:0];
      rd_beyond_q <= (32'(in_beat_i.slot) >= MAX_BINS);
      bin_q <= BinW'(in_beat_i.slot);
    end
    if (state_q == S_HI) begin
      lo_q <= edge_rdata;
    end
    if ((state_q == S_CHK) && chk_top) begin
      bin_q <= BinW'(n_bins - EdgeW'(1));
    end
    if ((state_q == S_SRCH) && step[Steps].valid) begin
      bin_q <= found_bin;
    end
  end

endmodule

>>> rtl/vehu_checker.sv
// ----------------------------------------------------------------------------
// vehu_checker
// Port-level checks of the edge histogram, bound to the top level.
// ----------------------------------------------------------------------------
`include "variable_edge_histogram_unit_macros.svh"

module vehu_checker
  import vehu_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input vehu_in_t  in_beat_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input vehu_out_t out_beat_o
);

  logic acc_load;
  logic acc_clear;
  logic acc_read;

  assign acc_load = in_valid_i && !in_stall_o && (in_beat_i.opcode == OP_LOAD);
  assign acc_clear = in_valid_i && !in_stall_o && (in_beat_i.opcode == OP_CLEAR);
  assign acc_read = in_valid_i && !in_stall_o && (in_beat_i.opcode == OP_READ);

  // Loads and clears finish in their own cycle.
  `VEHU_ASSERT_NEXT(a_load_one_cycle, acc_load, !in_stall_o, "load beat kept the unit busy")
  `VEHU_ASSERT_NEXT(a_clear_one_cycle, acc_clear, !in_stall_o, "clear beat kept the unit busy")
  // A read holds off input until its result is out.
  `VEHU_ASSERT_NEXT(a_read_busy, acc_read, in_stall_o, "read beat did not hold off input")
  `VEHU_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_beat_o), "stalled result changed")

endmodule

bind variable_edge_histogram_unit vehu_checker u_vehu_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_beat_i  (in_beat_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_beat_o (out_beat_o)
);

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the variable edge histogram unit.
// ----------------------------------------------------------------------------
// Beats are driven into the unit while a bit-level copy of the histogram, kept
// here, predicts every read result. Each read result is compared field by
// field with the oldest prediction. Both sides idle at random. The bench loads
// the whole edge table first, so no search ever touches an edge never written.
module tb_top;
  import vehu_pkg::*;

  localparam int unsigned NumBins   = 256;
  localparam int unsigned DrainWait = 40;
  localparam int unsigned CycleCap  = 1000000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [8:0] cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  vehu_in_t  in_beat_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  vehu_out_t out_beat_o;

  // Histogram copy: edges, counts and register values as the unit holds them.
  logic [63:0] edge_copy [NumBins+1];
  logic [31:0] count_copy [NumBins];
  logic        drop_zeros, drop_infs;
  logic [8:0]  bin_reg;

  vehu_out_t   pending_reads [$];
  bit          send_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  logic [8:0] bin_sweep [4] = '{9'd0, 9'd1, 9'd511, 9'd256};

  variable_edge_histogram_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The run stops here if the unit hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("** variable_edge_histogram_unit: FAILED **");
      $finish;
    end
  end

  // Double compare on raw bits. NaN never compares, and the two zeros are one
  // value. Mapping the sign into an unsigned key gives the total order.
  function automatic bit dbl_nan(logic [63:0] a);
    return a[62:52] == 11'h7FF && a[51:0] != 0;
  endfunction

  function automatic bit dbl_less(logic [63:0] a, logic [63:0] b);
    logic [63:0] ka, kb;
    ka = a[63] ? ~a : {1'b1, a[62:0]};
    kb = b[63] ? ~b : {1'b1, b[62:0]};
    if (dbl_nan(a) || dbl_nan(b)) return 1'b0;
    if (a[62:0] == 0 && b[62:0] == 0) return 1'b0;
    return ka < kb;
  endfunction

  function automatic bit dbl_same(logic [63:0] a, logic [63:0] b);
    if (dbl_nan(a) || dbl_nan(b)) return 1'b0;
    return a == b || (a[62:0] == 0 && b[62:0] == 0);
  endfunction

  function automatic int unsigned live_bins();
    if (bin_reg == 0) return 1;
    if (bin_reg > NumBins) return NumBins;
    return bin_reg;
  endfunction

  // Bin chosen for a kept sample: upper-bound search, clamped to the last bin.
  function automatic int bin_of_sample(logic [63:0] v, int unsigned n);
    int unsigned first, span, half, probe, bin;
    first = 0;
    span = n + 1;
    while (span > 0) begin
      half = span / 2;
      probe = first + half;
      if (probe > NumBins) probe = NumBins;
      if (!dbl_less(v, edge_copy[probe])) begin
        first = probe + 1;
        span -= half + 1;
      end else begin
        span = half;
      end
    end
    bin = (first == 0) ? 0 : first - 1;
    return (bin > n - 1) ? n - 1 : bin;
  endfunction

  // Applies one accepted beat to the copy and queues any read result.
  task automatic histogram_update(vehu_in_t b);
    int unsigned n, bin;
    vehu_out_t r;
    n = live_bins();
    case (b.opcode)
      OP_LOAD: if (b.slot <= NumBins) edge_copy[b.slot] = b.sample_bits;
      OP_SAMPLE: begin
        if (b.in_mask && !dbl_nan(b.sample_bits)
            && !(drop_zeros && b.sample_bits[62:0] == 0)
            && !(drop_infs && b.sample_bits[62:52] == 11'h7FF)
            && !dbl_less(b.sample_bits, edge_copy[0])
            && !dbl_less(edge_copy[n], b.sample_bits)) begin
          if (dbl_same(b.sample_bits, edge_copy[n])) bin = n - 1;
          else bin = bin_of_sample(b.sample_bits, n);
          if (count_copy[bin] != 32'hFFFF_FFFF) count_copy[bin]++;
        end
      end
      OP_READ: begin
        r.read_bin = b.slot[7:0];
        r.bin_total = (b.slot < NumBins) ? count_copy[b.slot] : '0;
        pending_reads = {pending_reads, r};
      end
      default: foreach (count_copy[i]) count_copy[i] = '0;
    endcase
  endtask

  // Sends one beat and waits for it to be taken. Valid stays high between
  // back-to-back beats and only drops for a random gap.
  task automatic send_beat(logic [1:0] op, logic [8:0] slot, logic [63:0] bits,
                           logic mask);
    vehu_in_t b;
    b.opcode = op;
    b.slot = slot;
    b.sample_bits = bits;
    b.in_mask = mask;
    if (send_gaps && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    histogram_update(b);
  endtask

  // Lets every read result arrive, then lets a dropped-result beat finish.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    wait_quiet();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SKIP_ZEROS: drop_zeros = val[0];
      CFG_SKIP_NANS:  ;
      CFG_SKIP_INFS:  drop_infs = val[0];
      default:        bin_reg = val;
    endcase
  endtask

  // Result checker with a random stall on the result side.
  always @(posedge clk_i) begin
    vehu_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_reads.size() == 0) begin
          $display("%0t: result beat with nothing expected, got bin %0d total %0d",
                   $time, out_beat_o.read_bin, out_beat_o.bin_total);
          errors++;
        end else begin
          want = pending_reads.pop_front();
          if (want.read_bin !== out_beat_o.read_bin) begin
            $display("%0t: read_bin expected %0d actual %0d", $time, want.read_bin,
                     out_beat_o.read_bin);
            errors++;
          end
          if (want.bin_total !== out_beat_o.bin_total) begin
            $display("%0t: bin_total expected %0d actual %0d", $time,
                     want.bin_total, out_beat_o.bin_total);
            errors++;
          end
        end
      end
      out_stall_i <= sink_stalls && ($urandom_range(99) < 10);
    end
  end

  // Sorted edges -128.0 .. 128.0, one unit apart.
  task automatic test_edge_load();
    for (int i = 0; i <= NumBins; i++)
      send_beat(OP_LOAD, 9'(i), $realtobits(real'(i) - 128.0), 1'b0);
    // Loads past the table must be ignored.
    send_beat(OP_LOAD, 9'd257, $realtobits(5.0), 1'b1);
    send_beat(OP_LOAD, 9'd511, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
  endtask

  // Edge values, the range ends, zeros, infinities, NaN and a masked sample.
  task automatic test_directed_samples();
    write_reg(CFG_BINS, 9'd256);
    send_beat(OP_SAMPLE, 0, $realtobits(-128.0), 1'b1);
    send_beat(OP_SAMPLE, 0, $realtobits(128.0), 1'b1);
    send_beat(OP_SAMPLE, 0, $realtobits(127.5), 1'b1);
    send_beat(OP_SAMPLE, 0, $realtobits(-129.0), 1'b1);
    send_beat(OP_SAMPLE, 0, $realtobits(128.25), 1'b1);
    send_beat(OP_SAMPLE, 0, 64'h0, 1'b1);
    send_beat(OP_SAMPLE, 0, 64'h8000_0000_0000_0000, 1'b1);
    send_beat(OP_SAMPLE, 0, 64'h7FF8_0000_0000_0001, 1'b1);
    send_beat(OP_SAMPLE, 0, 64'h7FF0_0000_0000_0000, 1'b1);
    send_beat(OP_SAMPLE, 0, 64'hFFF0_0000_0000_0000, 1'b1);
    send_beat(OP_SAMPLE, 0, $realtobits(3.0), 1'b0);
    send_beat(OP_READ, 9'd0, '1, 1'b1);
    send_beat(OP_READ, 9'd128, '0, 1'b0);
    send_beat(OP_READ, 9'd255, '0, 1'b0);
    send_beat(OP_READ, 9'd131, '0, 1'b0);
    send_beat(OP_READ, 9'd256, '0, 1'b0);
    send_beat(OP_READ, 9'd511, '0, 1'b0);
    send_beat(OP_CLEAR, 0, '0, 1'b0);
    send_beat(OP_READ, 9'd128, '0, 1'b0);
  endtask

  // Every register at its extremes, with zeros and infinities inside range.
  task automatic test_register_extremes();
    write_reg(CFG_SKIP_ZEROS, 9'd1);
    write_reg(CFG_SKIP_NANS, 9'd1);
    write_reg(CFG_SKIP_INFS, 9'd0);
    send_beat(OP_LOAD, 9'd0, 64'hFFF0_0000_0000_0000, 1'b0);
    send_beat(OP_LOAD, 9'd256, 64'h7FF0_0000_0000_0000, 1'b0);
    send_beat(OP_SAMPLE, 0, 64'h0, 1'b1);
    send_beat(OP_SAMPLE, 0, 64'h7FF0_0000_0000_0000, 1'b1);
    send_beat(OP_SAMPLE, 0, 64'hFFF0_0000_0000_0000, 1'b1);
    send_beat(OP_READ, 9'd0, '0, 1'b0);
    send_beat(OP_READ, 9'd255, '0, 1'b0);
    write_reg(CFG_SKIP_INFS, 9'd1);
    write_reg(CFG_SKIP_ZEROS, 9'd0);
    // Bin count zero acts as one bin, above the table as the full table.
    foreach (bin_sweep[i]) begin
      write_reg(CFG_BINS, bin_sweep[i]);
      send_beat(OP_SAMPLE, 0, 64'h7FF0_0000_0000_0000, 1'b1);
      send_beat(OP_SAMPLE, 0, 64'h8000_0000_0000_0000, 1'b1);
      send_beat(OP_SAMPLE, 0, $realtobits(-127.0), 1'b1);
      send_beat(OP_READ, 9'd0, '0, 1'b0);
      send_beat(OP_READ, 9'd1, '0, 1'b0);
      send_beat(OP_READ, 9'd255, '0, 1'b0);
    end
  endtask

  function automatic logic [63:0] pick_sample();
    logic [63:0] base;
    base = edge_copy[$urandom_range(NumBins)];
    case ($urandom_range(9))
      0, 1, 2: return base;
      3, 4, 5: return base + $urandom_range(8) - 4;
      6:       return {$urandom, $urandom};
      7:       return {1'($urandom_range(1)), 11'h7FF, 20'($urandom_range(1)), 32'h0};
      8:       return {1'($urandom_range(1)), 63'h0};
      default: return $realtobits(real'(int'($urandom_range(600)) - 300) / 2.0);
    endcase
  endfunction

  // Mostly samples and reads, with occasional reloads and clears.
  task automatic run_random(int unsigned beats, bit messy_edges);
    int unsigned p;
    logic [8:0] s;
    for (int unsigned k = 0; k < beats; k++) begin
      p = $urandom_range(99);
      s = 9'((p[0]) ? $urandom_range(live_bins()) : $urandom_range(511));
      if (p < 65) begin
        send_beat(OP_SAMPLE, 9'($urandom), pick_sample(), $urandom_range(9) != 0);
      end else if (p < 88) begin
        send_beat(OP_READ, s, {$urandom, $urandom}, 1'($urandom));
      end else if (p < 98) begin
        if (messy_edges) send_beat(OP_LOAD, s, {$urandom, $urandom}, 1'($urandom));
        else send_beat(OP_LOAD, 9'(257 + $urandom_range(254)), {$urandom, $urandom},
                       1'($urandom));
      end else begin
        send_beat(OP_CLEAR, 9'($urandom), {$urandom, $urandom}, 1'($urandom));
      end
    end
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_SKIP_ZEROS, 9'($urandom_range(1)));
      write_reg(CFG_SKIP_NANS, 9'($urandom_range(1)));
      write_reg(CFG_SKIP_INFS, 9'($urandom_range(1)));
      write_reg(CFG_BINS, 9'((ph % 3 == 0) ? $urandom_range(1, 8) : $urandom_range(511)));
      // One phase runs with neither side idling.
      send_gaps = (ph != 3);
      sink_stalls = (ph != 3);
      run_random(120, 1'b0);
      // Hold off until every read result is back, then resume.
      if (ph == 5) begin
        in_valid_i <= 1'b0;
        while (pending_reads.size() != 0) @(posedge clk_i);
      end
      // Reads are frequent, so results keep pace; unsorted and NaN edges later.
      run_random(120, ph >= 6);
    end
  endtask

  initial begin
    drop_zeros = 1'b0;
    drop_infs = 1'b0;
    bin_reg = 9'd1;
    foreach (count_copy[i]) count_copy[i] = '0;
    foreach (edge_copy[i]) edge_copy[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_load();
    test_directed_samples();
    test_register_extremes();
    test_random_phases();
    wait_quiet();
    if (errors == 0) begin
      $display("** variable_edge_histogram_unit: PASSED **");
    end else begin
      $display("** variable_edge_histogram_unit: FAILED **");
    end
    $finish;
  end

endmodule
